@@ sv/wht_pkg.sv @@
// ----------------------------------------------------------------------------
// wht_pkg: shared definitions for the Walsh-Hadamard transform core.
// Holds the default parameter values and the length register's format.
// ----------------------------------------------------------------------------
`default_nettype none

package wht_pkg;

    localparam int DEF_MAX_LOG2_LEN = 6;
    localparam int DEF_SAMPLE_WIDTH = 16;

    localparam int CFG_WIDTH = 3;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 3'd6;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_BF_RD = 6'b000010,
        ST_BF_WA = 6'b000100,
        ST_BF_WB = 6'b001000,
        ST_EM_RD = 6'b010000,
        ST_EM_WR = 6'b100000
    } state_t;

    function automatic int stage_width(input int max_log2);
        int w;
        w = 1;
        while ((1 << w) <= max_log2) begin
            w = w + 1;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

@@ sv/wht_agen.sv @@
// ----------------------------------------------------------------------------
// wht_agen: butterfly address generator.
// Maps a stage number and a pair number to the two buffer addresses that the
// butterfly combines, and flags the final pair and the final stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wht_agen #(
    parameter int MAX_LOG2_LEN = wht_pkg::DEF_MAX_LOG2_LEN
) (
    input  wire logic [wht_pkg::stage_width(MAX_LOG2_LEN)-1:0] stage,
    input  wire logic [wht_pkg::stage_width(MAX_LOG2_LEN)-1:0] k_act,
    input  wire logic [MAX_LOG2_LEN-1:0]                       pair,
    output logic      [MAX_LOG2_LEN-1:0]                       addr_a,
    output logic      [MAX_LOG2_LEN-1:0]                       addr_b,
    output logic                                               last_pair,
    output logic                                               last_stage
);

    localparam int AW = MAX_LOG2_LEN;
    localparam int KW = wht_pkg::stage_width(MAX_LOG2_LEN);

    logic [AW-1:0] lo_mask;
    logic [AW-1:0] stride_bit;
    logic [AW-1:0] n_mask;

    always_comb
    begin
        lo_mask    = ~({AW{1'b1}} << stage);
        stride_bit = AW'(1) << stage;
        n_mask     = ~({AW{1'b1}} << k_act);
        addr_a     = ((pair & ~lo_mask) << 1) | (pair & lo_mask);
        addr_b     = addr_a | stride_bit;
        last_pair  = (pair == (n_mask >> 1));
        last_stage = (stage == (k_act - KW'(1)));
    end

endmodule

`default_nettype wire

@@ sv/walsh_hadamard_transform_core.sv @@
// ----------------------------------------------------------------------------
// walsh_hadamard_transform_core: unnormalized fast Walsh-Hadamard transform.
// The core takes N = 2^k signed samples, one per input beat, where k is the
// length register (0 acts as 1, values above MAX_LOG2_LEN act as
// MAX_LOG2_LEN; a write restarts loading). It then runs k butterfly stages in
// place on one buffer memory and sends the N coefficients in natural order,
// with the position in tuser and tlast on the final one. Each butterfly
// reads both operands, writes the sum, then writes the difference in a
// separate state, because the buffer has one write port. Each coefficient
// is read from the buffer, then moved to the output register once that
// register is free. No input beat is taken while a vector is transformed
// or sent.
// ----------------------------------------------------------------------------
`default_nettype none

module walsh_hadamard_transform_core #(
    parameter int MAX_LOG2_LEN = wht_pkg::DEF_MAX_LOG2_LEN,
    parameter int SAMPLE_WIDTH = wht_pkg::DEF_SAMPLE_WIDTH
) (
    input  wire logic                                              clk,
    input  wire logic                                              rst_n,
    input  wire logic                                              cfg_we,
    input  wire logic [wht_pkg::CFG_WIDTH-1:0]                     cfg_wdata,
    input  wire logic                                              s_tvalid,
    output logic                                                   s_tready,
    // Fields from bit 0: sample.
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]                 s_tdata,
    output logic                                                   m_tvalid,
    input  wire logic                                              m_tready,
    // Fields from bit 0: coefficient.
    output logic [((SAMPLE_WIDTH+MAX_LOG2_LEN+7)/8)*8-1:0]         m_tdata,
    // Fields from bit 0: position.
    output logic [MAX_LOG2_LEN-1:0]                                m_tuser,
    output logic                                                   m_tlast
);

    localparam int AW    = MAX_LOG2_LEN;
    localparam int KW    = wht_pkg::stage_width(MAX_LOG2_LEN);
    localparam int CW    = SAMPLE_WIDTH + MAX_LOG2_LEN;
    localparam int DEPTH = 1 << MAX_LOG2_LEN;
    localparam int TDW   = ((SAMPLE_WIDTH + MAX_LOG2_LEN + 7) / 8) * 8;

    wht_pkg::state_t                 state_reg, state_next;
    logic [wht_pkg::CFG_WIDTH-1:0]   cfg_reg;
    logic [AW-1:0]                   load_cnt_reg, load_cnt_next;
    logic [KW-1:0]                   stage_reg, stage_next;
    logic [AW-1:0]                   pair_reg, pair_next;
    logic [AW-1:0]                   emit_idx_reg, emit_idx_next;
    logic signed [CW-1:0]            diff_reg, diff_next;
    logic                            out_valid_reg, out_valid_next;
    logic [CW-1:0]                   coef_reg, coef_next;
    logic [AW-1:0]                   pos_reg, pos_next;
    logic                            last_reg, last_next;

    logic [CW-1:0]                   buf_mem [0:DEPTH-1];
    logic signed [CW-1:0]            rda_reg, rdb_reg;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [CW-1:0]                   mem_wdata;
    logic [AW-1:0]                   mem_raddr;

    logic [KW-1:0]                   k_act;
    logic [AW-1:0]                   n_mask;
    logic [AW-1:0]                   addr_a, addr_b;
    logic                            last_pair, last_stage;
    logic signed [CW-1:0]            sample_ext;
    logic                            in_beat, out_free;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            k_act = KW'(1);
        end
        else if (32'(cfg_reg) > MAX_LOG2_LEN)
        begin
            k_act = KW'(MAX_LOG2_LEN);
        end
        else
        begin
            k_act = KW'(cfg_reg);
        end
    end

    assign n_mask     = ~({AW{1'b1}} << k_act);
    assign sample_ext = CW'($signed(s_tdata[SAMPLE_WIDTH-1:0]));
    assign s_tready   = (state_reg == wht_pkg::ST_LOAD);
    assign in_beat    = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;

    wht_agen #(
        .MAX_LOG2_LEN (MAX_LOG2_LEN)
    ) u_agen (
        .stage      (stage_reg),
        .k_act      (k_act),
        .pair       (pair_reg),
        .addr_a     (addr_a),
        .addr_b     (addr_b),
        .last_pair  (last_pair),
        .last_stage (last_stage)
    );

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        stage_next     = stage_reg;
        pair_next      = pair_reg;
        emit_idx_next  = emit_idx_reg;
        diff_next      = diff_reg;
        out_valid_next = out_valid_reg && !m_tready;
        coef_next      = coef_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_waddr      = addr_a;
        mem_wdata      = CW'(rda_reg + rdb_reg);
        mem_raddr      = (state_reg == wht_pkg::ST_BF_RD) ? addr_a : emit_idx_reg;

        unique case (state_reg)
            wht_pkg::ST_LOAD:
            begin
                if (in_beat)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = load_cnt_reg;
                    mem_wdata = sample_ext;
                    if (load_cnt_reg == n_mask)
                    begin
                        load_cnt_next = '0;
                        stage_next    = '0;
                        pair_next     = '0;
                        state_next    = wht_pkg::ST_BF_RD;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + AW'(1);
                    end
                end
            end
            wht_pkg::ST_BF_RD:
            begin
                state_next = wht_pkg::ST_BF_WA;
            end
            wht_pkg::ST_BF_WA:
            begin
                mem_we     = 1'b1;
                diff_next  = rda_reg - rdb_reg;
                state_next = wht_pkg::ST_BF_WB;
            end
            wht_pkg::ST_BF_WB:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_b;
                mem_wdata = diff_reg;
                if (!last_pair)
                begin
                    pair_next  = pair_reg + AW'(1);
                    state_next = wht_pkg::ST_BF_RD;
                end
                else if (!last_stage)
                begin
                    pair_next  = '0;
                    stage_next = stage_reg + KW'(1);
                    state_next = wht_pkg::ST_BF_RD;
                end
                else
                begin
                    emit_idx_next = '0;
                    state_next    = wht_pkg::ST_EM_RD;
                end
            end
            wht_pkg::ST_EM_RD:
            begin
                state_next = wht_pkg::ST_EM_WR;
            end
            wht_pkg::ST_EM_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    coef_next      = rda_reg;
                    pos_next       = emit_idx_reg;
                    last_next      = (emit_idx_reg == n_mask);
                    if (emit_idx_reg == n_mask)
                    begin
                        state_next = wht_pkg::ST_LOAD;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + AW'(1);
                        state_next    = wht_pkg::ST_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = wht_pkg::ST_LOAD;
            end
        endcase

        if (cfg_we)
        begin
            load_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wht_pkg::ST_LOAD;
            cfg_reg       <= wht_pkg::CFG_RESET;
            load_cnt_reg  <= '0;
            stage_reg     <= '0;
            pair_reg      <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            stage_reg     <= stage_next;
            pair_reg      <= pair_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        coef_reg <= coef_next;
        pos_reg  <= pos_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            buf_mem[mem_waddr] <= mem_wdata;
        end
        rda_reg <= buf_mem[mem_raddr];
        rdb_reg <= buf_mem[addr_b];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDW'(coef_reg);
    assign m_tuser  = pos_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    // The final input beat of a vector starts the first butterfly.
    a_start_transform: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && !cfg_we && load_cnt_reg == n_mask) |=> (state_reg == wht_pkg::ST_BF_RD))
        else $error("transform did not start after the final sample");

    // The stage counter never reaches the number of stages in use.
    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != wht_pkg::ST_LOAD) |-> (stage_reg < k_act))
        else $error("stage counter out of range");

    // The flagged coefficient is the one at the highest position.
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == n_mask))
        else $error("tlast on a coefficient other than the final one");

    // Loading the final coefficient returns the core to loading.
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wht_pkg::ST_EM_WR && out_free && emit_idx_reg == n_mask)
        |=> (state_reg == wht_pkg::ST_LOAD && m_tvalid && m_tlast))
        else $error("core did not return to loading after the final coefficient");
`endif

endmodule

`default_nettype wire

@@ bench/walsh_hadamard_transform_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for walsh_hadamard_transform_core.
// Samples stream in on the slave side, and a predictor runs the butterfly
// stages on its own copy of the vector. Every coefficient beat that arrives
// on the master side is checked against the oldest prediction. Beats carry
// the coefficient, its position and the last flag. Directed vectors cover
// the sample extremes, the clamping of a zero length, and a restart
// after a register write in the middle of a vector. Random phases with
// idle cycles on both sides of the core follow, then phases with none.
// ----------------------------------------------------------------------------

module walsh_hadamard_transform_core_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int BUF_DEPTH = 64;

    typedef struct packed {
        logic [21:0] coef;
        logic [5:0]  pos;
        logic        last;
    } coef_beat_t;

    class wht_scoreboard;
        logic [wht_pkg::CFG_WIDTH-1:0] length_reg;
        int                            load_count;
        int                            vec_buf [BUF_DEPTH];
        coef_beat_t                    expected_coefs [$];
        int                            errors;

        function void set_length(logic [wht_pkg::CFG_WIDTH-1:0] v);
            length_reg = v;
            load_count = 0;
        endfunction

        function int pending();
            return expected_coefs.size();
        endfunction

        function void note_sample(logic [15:0] v);
            int         k;
            int         n;
            int         half;
            int         base;
            int         off;
            int         a;
            int         b;
            coef_beat_t beat;
            k = (length_reg < 1) ? 1 : ((length_reg > 6) ? 6 : int'(length_reg));
            n = 1 << k;
            if (load_count >= n)
                load_count = 0;
            vec_buf[load_count] = int'($signed(v));
            load_count++;
            if (load_count < n)
                return;
            load_count = 0;
            for (int s = 0; s < k; s++)
            begin
                half = 1 << s;
                for (base = 0; base < n; base += 2 * half)
                begin
                    for (off = 0; off < half; off++)
                    begin
                        a = vec_buf[base + off];
                        b = vec_buf[base + off + half];
                        vec_buf[base + off] = a + b;
                        vec_buf[base + off + half] = a - b;
                    end
                end
            end
            for (int i = 0; i < n; i++)
            begin
                beat.coef = vec_buf[i][21:0];
                beat.pos = i[5:0];
                beat.last = (i == n - 1);
                expected_coefs.push_back(beat);
            end
        endfunction

        function void check_coefficient(logic [21:0] coef, logic [5:0] pos, logic last);
            coef_beat_t exp_beat;
            if (expected_coefs.size() == 0)
            begin
                $display("%0t: unexpected beat, coefficient %0d position %0d last %0b",
                         $time, $signed(coef), pos, last);
                errors++;
                return;
            end
            exp_beat = expected_coefs.pop_front();
            if (coef !== exp_beat.coef)
            begin
                $display("%0t: coefficient expected %0d actual %0d", $time,
                         $signed(exp_beat.coef), $signed(coef));
                errors++;
            end
            if (pos !== exp_beat.pos)
            begin
                $display("%0t: position expected %0d actual %0d", $time, exp_beat.pos, pos);
                errors++;
            end
            if (last !== exp_beat.last)
            begin
                $display("%0t: last expected %0b actual %0b", $time, exp_beat.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [wht_pkg::CFG_WIDTH-1:0] cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [15:0]                   s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [23:0]                   m_tdata;
    logic [5:0]                    m_tuser;
    logic                          m_tlast;

    wht_scoreboard model;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            cycles;

    walsh_hadamard_transform_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            model.check_coefficient(m_tdata[21:0], m_tuser, m_tlast);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("walsh_hadamard_transform_core: mismatch");
            $finish;
        end
    end

    task automatic push_sample(input logic [15:0] v);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do
            @(posedge clk);
        while (!s_tready);
        model.note_sample(v);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length(input logic [wht_pkg::CFG_WIDTH-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        model.set_length(v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 26;
                recv_idle_pct = 67;
            end
            1:
            begin
                send_idle_pct = 67;
                recv_idle_pct = 26;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'h8000;
            1: v = 16'h7fff;
            2: v = 16'hffff;
            3: v = 16'h0000;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    initial
    begin
        logic [wht_pkg::CFG_WIDTH-1:0] phase_len [6];
        logic [wht_pkg::CFG_WIDTH-1:0] len;
        int                            n;
        int                            vectors;

        model = new();
        model.set_length(wht_pkg::CFG_RESET);
        model.errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        set_idling(0);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A length of zero runs as two points.
        write_length(3'd0);
        push_sample(16'h7fff);
        push_sample(16'h8000);
        push_sample(16'h8000);
        push_sample(16'h8000);
        write_length(3'd1);
        push_sample(16'h8000);
        push_sample(16'h7fff);
        push_sample(16'h0000);
        push_sample(16'hffff);
        // A write in the middle of a vector drops the samples loaded so far.
        write_length(3'd2);
        push_sample(16'h0001);
        push_sample(16'h0002);
        push_sample(16'h0003);
        write_length(3'd2);
        push_sample(16'h7fff);
        push_sample(16'h7fff);
        push_sample(16'h7fff);
        push_sample(16'h7fff);

        phase_len = '{3'd0, 3'd7, 3'd1, 3'd3, 3'd2, 3'd4};
        for (int phase = 0; phase < 6; phase++)
        begin
            set_idling(phase / 2);
            len = phase_len[phase];
            write_length(len);
            n = 1 << ((len < 1) ? 1 : ((len > 6) ? 6 : int'(len)));
            vectors = (n <= 4) ? $urandom_range(1, 2) : 1;
            repeat (vectors * n) push_sample(pick_sample());
            if (n <= 8 && $urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, n - 1)) push_sample(pick_sample());
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (model.errors == 0 && model.pending() == 0)
            $display("walsh_hadamard_transform_core: match");
        else
            $display("walsh_hadamard_transform_core: mismatch");
        $finish;
    end

endmodule
